// ----- rtl/elmd_pkg.sv -----
// Package for the EFUSE logical map decoder: field widths, command, phase and
// status codes, channel payload structs and controller/datapath link structs.
// No dependencies.
package elmd_pkg;

	localparam int PHYS_SIZE_DEF = 1024;
	localparam int MAP_SIZE_DEF  = 512;

	localparam int CMD_W  = 2;
	localparam int BYTE_W = 8;
	localparam int ADDR_W = 9;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 11;
	localparam int BASE_W = 10;
	localparam int PH_W   = 3;

	localparam logic [CMD_W-1:0] CMD_START = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FAIL  = 2'd3;

	localparam logic [PH_W-1:0] PH_IDLE = 3'd0;
	localparam logic [PH_W-1:0] PH_HDR  = 3'd1;
	localparam logic [PH_W-1:0] PH_HDR2 = 3'd2;
	localparam logic [PH_W-1:0] PH_DATA = 3'd3;
	localparam logic [PH_W-1:0] PH_DONE = 3'd4;
	localparam logic [PH_W-1:0] PH_FAIL = 3'd5;

	localparam logic [STAT_W-1:0] STAT_IDLE   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BUSY   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DONE   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FAILED = 2'd3;

	localparam logic [BYTE_W-1:0] BYTE_ERASED = 8'hFF;
	localparam logic [4:0]        EXT_MASK    = 5'h1F;
	localparam logic [4:0]        EXT_CODE    = 5'h0F;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [BYTE_W-1:0] data_byte;
		logic [ADDR_W-1:0] map_address;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              map_valid;
		logic [STAT_W-1:0] decode_status;
		logic [CNT_W-1:0]  bytes_consumed;
	} result_t;

	typedef struct packed {
		logic start;
		logic take_byte;
		logic abort;
		logic rd_issue;
		logic load_out;
		logic load_ram;
		logic clr_en;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
	} dp_sts_t;

endpackage

// ----- rtl/elmd_stream_if.sv -----
// Valid/ready stream channel carrying one payload struct per transfer.
// Payload type is a parameter; see elmd_pkg for the structs in use.
interface elmd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/elmd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module elmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/elmd_datapath.sv -----
// Decoder datapath: header/word parse registers, byte counter, map RAM,
// clear counter and result register. Depends on elmd_pkg and elmd_ram.
module elmd_datapath import elmd_pkg::*; #(
	parameter int PHYS_SIZE = PHYS_SIZE_DEF,
	parameter int MAP_SIZE  = MAP_SIZE_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  dp_cmd_t cmd,
	input  item_t   item,
	output dp_sts_t sts,
	output result_t result
);
	localparam int MAP_AW = $clog2(MAP_SIZE);
	localparam logic [CNT_W-1:0]  PHYS_END = CNT_W'(PHYS_SIZE);
	localparam logic [CNT_W-1:0]  MAP_LIM  = CNT_W'(MAP_SIZE);
	localparam logic [MAP_AW-1:0] CLR_LAST = MAP_AW'(MAP_SIZE - 1);

	logic [PH_W-1:0]   phase_q, phase_n;
	logic [BYTE_W-1:0] first_hdr_q, first_hdr_n;
	logic [BASE_W-1:0] base_q, base_n;
	logic [3:0]        mask_q, mask_n;
	logic [1:0]        pos_q, pos_n;
	logic              biw_q, biw_n;
	logic [CNT_W-1:0]  count_q, count_n, count_inc;
	logic              valid_q, valid_n;
	logic [MAP_AW-1:0] clr_cnt_q;
	logic              rd_hit_q;
	result_t           result_q;

	logic [BASE_W-1:0] word_addr, wr_addr;
	logic              wr_en;
	logic              nw_en;
	logic [2:0]        nw_from, nw_sel;
	logic [3:0]        nw_mask;
	logic [BYTE_W-1:0] b;
	logic [STAT_W-1:0] stat_n;
	logic [BYTE_W-1:0] ram_rdata;
	logic              ram_we;
	logic [MAP_AW-1:0] ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic [BASE_W-1:0] rd_addr_ext;

	function automatic logic [2:0] first_free(input logic [3:0] mask, input logic [2:0] from);
		logic [2:0] r;
		r = 3'd4;
		for (int p = 3; p >= 0; p--) begin
			if ((3'(p) >= from) && !mask[p]) begin
				r = 3'(p);
			end
		end
		return r;
	endfunction

	assign b         = item.data_byte;
	assign count_inc = (count_q != {CNT_W{1'b1}}) ? count_q + CNT_W'(1) : count_q;
	assign word_addr = base_q + {{(BASE_W-3){1'b0}}, pos_q, 1'b0};
	assign wr_addr   = word_addr + {{(BASE_W-1){1'b0}}, biw_q};

	always_comb begin
		phase_n     = phase_q;
		first_hdr_n = first_hdr_q;
		base_n      = base_q;
		mask_n      = mask_q;
		pos_n       = pos_q;
		biw_n       = biw_q;
		count_n     = count_q;
		valid_n     = valid_q;
		wr_en       = 1'b0;
		nw_en       = 1'b0;
		nw_from     = 3'd0;
		nw_mask     = mask_q;
		nw_sel      = 3'd4;
		if (cmd.start) begin
			phase_n     = PH_HDR;
			first_hdr_n = '0;
			base_n      = '0;
			mask_n      = 4'hF;
			pos_n       = '0;
			biw_n       = 1'b0;
			count_n     = '0;
			valid_n     = 1'b0;
		end else if (cmd.abort) begin
			if (phase_q == PH_HDR || phase_q == PH_HDR2 || phase_q == PH_DATA) begin
				phase_n = PH_FAIL;
				valid_n = 1'b0;
			end
		end else if (cmd.take_byte) begin
			case (phase_q)
				PH_HDR: begin
					if (b == BYTE_ERASED) begin
						phase_n = PH_DONE;
						valid_n = 1'b1;
					end else begin
						count_n = count_inc;
						if ((b[4:0] & EXT_MASK) == EXT_CODE) begin
							first_hdr_n = b;
							phase_n     = PH_HDR2;
						end else begin
							base_n  = {3'b000, b[7:4], 3'b000};
							mask_n  = b[3:0];
							nw_en   = 1'b1;
							nw_mask = b[3:0];
						end
					end
				end
				PH_HDR2: begin
					count_n = count_inc;
					base_n  = {b[7:4], first_hdr_q[7:5], 3'b000};
					mask_n  = b[3:0];
					nw_en   = 1'b1;
					nw_mask = b[3:0];
				end
				PH_DATA: begin
					count_n = count_inc;
					wr_en   = ({1'b0, word_addr} + CNT_W'(1)) < MAP_LIM;
					if (!biw_q) begin
						biw_n = 1'b1;
					end else begin
						nw_en   = 1'b1;
						nw_from = {1'b0, pos_q} + 3'd1;
					end
				end
				default: begin
				end
			endcase
			if (nw_en) begin
				nw_sel = first_free(nw_mask, nw_from);
				if (nw_sel[2]) begin
					if (count_n >= PHYS_END) begin
						phase_n = PH_DONE;
						valid_n = 1'b1;
					end else begin
						phase_n = PH_HDR;
					end
				end else begin
					phase_n = PH_DATA;
					pos_n   = nw_sel[1:0];
					biw_n   = 1'b0;
				end
			end
		end
	end

	always_comb begin
		case (phase_n)
			PH_HDR, PH_HDR2, PH_DATA: stat_n = STAT_BUSY;
			PH_DONE:                  stat_n = STAT_DONE;
			PH_FAIL:                  stat_n = STAT_FAILED;
			default:                  stat_n = STAT_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			first_hdr_q <= '0;
			base_q      <= '0;
			mask_q      <= 4'hF;
			pos_q       <= '0;
			biw_q       <= 1'b0;
			count_q     <= '0;
			valid_q     <= 1'b0;
			clr_cnt_q   <= '0;
		end else begin
			phase_q     <= phase_n;
			first_hdr_q <= first_hdr_n;
			base_q      <= base_n;
			mask_q      <= mask_n;
			pos_q       <= pos_n;
			biw_q       <= biw_n;
			count_q     <= count_n;
			valid_q     <= valid_n;
			if (cmd.start) begin
				clr_cnt_q <= '0;
			end else if (cmd.clr_en) begin
				clr_cnt_q <= clr_cnt_q + MAP_AW'(1);
			end
		end
	end

	assign rd_addr_ext = {{(BASE_W-ADDR_W){1'b0}}, item.map_address};

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rd_hit_q <= valid_q && ({{(CNT_W-ADDR_W){1'b0}}, item.map_address} < MAP_LIM);
		end
		if (cmd.load_out) begin
			result_q.read_data      <= (cmd.load_ram && rd_hit_q) ? ram_rdata : BYTE_ERASED;
			result_q.map_valid      <= valid_n;
			result_q.decode_status  <= stat_n;
			result_q.bytes_consumed <= count_n;
		end
	end

	assign ram_we    = cmd.clr_en || wr_en;
	assign ram_waddr = cmd.clr_en ? clr_cnt_q : wr_addr[MAP_AW-1:0];
	assign ram_wdata = cmd.clr_en ? BYTE_ERASED : b;

	elmd_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAP_SIZE)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr_ext[MAP_AW-1:0]),
		.rdata (ram_rdata)
	);

	assign sts.clr_last = (clr_cnt_q == CLR_LAST);
	assign result       = result_q;
endmodule

// ----- rtl/elmd_ctrl.sv -----
// Decoder controller: handshake, result register valid, map clear sweep and
// map read wait sequencing. Depends on elmd_pkg.
module elmd_ctrl import elmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic [CMD_W-1:0] item_command,
	output logic             item_ready,
	output logic             result_valid,
	input  logic             result_ready,
	input  dp_sts_t          sts,
	output dp_cmd_t          cmd
);
	localparam logic [1:0] ST_RUN    = 2'd0;
	localparam logic [1:0] ST_CLEAR  = 2'd1;
	localparam logic [1:0] ST_RDWAIT = 2'd2;

	logic [1:0] state_q, state_n;
	logic       out_valid_q;
	logic       acc;

	assign item_ready = (state_q == ST_RUN) && (!out_valid_q || result_ready);
	assign acc        = item_valid && item_ready;

	always_comb begin
		cmd.start     = acc && (item_command == CMD_START);
		cmd.take_byte = acc && (item_command == CMD_BYTE);
		cmd.rd_issue  = acc && (item_command == CMD_READ);
		cmd.abort     = acc && (item_command == CMD_FAIL);
		cmd.load_ram  = (state_q == ST_RDWAIT);
		cmd.load_out  = (acc && (item_command != CMD_READ)) || (state_q == ST_RDWAIT);
		cmd.clr_en    = (state_q == ST_CLEAR);
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_RUN: begin
				if (cmd.start) begin
					state_n = ST_CLEAR;
				end else if (cmd.rd_issue) begin
					state_n = ST_RDWAIT;
				end
			end
			ST_CLEAR: begin
				if (sts.clr_last) begin
					state_n = ST_RUN;
				end
			end
			ST_RDWAIT: state_n = ST_RUN;
			default:   state_n = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

`ifndef SYNTHESIS
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !item_ready)
		else $error("item taken during map clear");
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == ST_CLEAR))
		else $error("start did not begin map clear");
	a_read_waits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |=> (state_q == ST_RDWAIT))
		else $error("map read did not wait for ram data");
	a_rdwait_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDWAIT) |-> !out_valid_q)
		else $error("result register busy when ram data returns");
`endif
endmodule

// ----- rtl/efuse_logical_map_decoder.sv -----
// Top level of the EFUSE logical map decoder: controller plus datapath.
// Depends on elmd_pkg, elmd_stream_if, elmd_ctrl, elmd_datapath.
//
// channel   dir  payload    contents
// item      in   item_t     command, data_byte, map_address
// result    out  result_t   read_data, map_valid, decode_status, bytes_consumed
//
// Physical byte, read-fail and start commands load the result register in the
// cycle they are accepted; a map read passes through a wait state, set by the
// registered read port of the map RAM. A start is followed by a clear sweep
// of every map RAM address during which no item is accepted. Reset needs no
// sweep: the map reads as 0xFF until a decode started after reset completes.
// One result register separates the channels; a stalled result blocks the
// next item only while it is still held.
module efuse_logical_map_decoder import elmd_pkg::*; #(
	parameter int PHYS_SIZE = PHYS_SIZE_DEF,
	parameter int MAP_SIZE  = MAP_SIZE_DEF
) (
	input logic           clk,
	input logic           arst_n,
	elmd_stream_if.sink   item,
	elmd_stream_if.source result
);
	dp_cmd_t cmd;
	dp_sts_t sts;
	item_t   item_pl;
	result_t result_pl;

	assign item_pl        = item.payload;
	assign result.payload = result_pl;

	elmd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_command (item_pl.command),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	elmd_datapath #(
		.PHYS_SIZE (PHYS_SIZE),
		.MAP_SIZE  (MAP_SIZE)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item_pl),
		.sts    (sts),
		.result (result_pl)
	);
endmodule
